// ===== sv/hosp_pkg.sv =====
// Shared types and constants for the hunk object stream parser.
// Used by hosp_step and hunk_object_stream_parser; depends on nothing.
`timescale 1ns / 1ps

package hosp_pkg;

    // Width of the saturating hunk and defined-symbol counters
    localparam int COUNT_WIDTH = 16;
    localparam logic [COUNT_WIDTH-1:0] COUNT_ONE = COUNT_WIDTH'(1);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    localparam int WORD_W = 32;
    localparam int ROLE_W = 4;
    localparam int TDATA_W = 96;

    // Block codes (matched on the low 16 bits); the hunk end word is matched in all 32 bits
    localparam logic [15:0] BLK_UNIT     = 16'h03E7;
    localparam logic [15:0] BLK_NAME     = 16'h03E8;
    localparam logic [15:0] BLK_CODE     = 16'h03E9;
    localparam logic [15:0] BLK_DATA     = 16'h03EA;
    localparam logic [15:0] BLK_BSS      = 16'h03EB;
    localparam logic [15:0] BLK_RELOC32  = 16'h03EC;
    localparam logic [15:0] BLK_RELOC16  = 16'h03ED;
    localparam logic [15:0] BLK_RELOC8   = 16'h03EE;
    localparam logic [15:0] BLK_DRELOC32 = 16'h03F8;
    localparam logic [15:0] BLK_EXT      = 16'h03EF;
    localparam logic [15:0] BLK_SYMBOL   = 16'h03F0;
    localparam logic [15:0] BLK_DEBUG    = 16'h03F1;
    localparam logic [31:0] WORD_END     = 32'h0000_03F2;

    localparam logic [23:0] SYM_LEN_MASK = 24'hFF_FFFF;
    localparam logic [7:0]  SYM_COMMON   = 8'd130;

    typedef enum logic [4:0] {
        PH_UNIT, PH_UNIT_LEN, PH_UNIT_NAME, PH_HUNK_START, PH_HNAME_LEN,
        PH_HNAME, PH_BLOCK, PH_CONT_LEN, PH_CONTENT, PH_BSS_LEN,
        PH_DEBUG_LEN, PH_RELOC_COUNT, PH_RELOC_TARGET, PH_RELOC_OFFS,
        PH_SYM_HDR, PH_SYM_NAME, PH_SYM_VALUE, PH_REF_COUNT, PH_REF_OFFS,
        PH_ERROR
    } t_phase;

    typedef enum logic [ROLE_W-1:0] {
        ROLE_UNIT_ID, ROLE_LENGTH, ROLE_NAME, ROLE_NAME_ID, ROLE_BLOCK,
        ROLE_CONTENT, ROLE_COUNT, ROLE_RELOC_TARGET, ROLE_RELOC_OFFS,
        ROLE_SYM_HDR, ROLE_SYM_VALUE, ROLE_REFERENCE, ROLE_HUNK_END,
        ROLE_IGNORED
    } t_role;

    typedef enum logic [2:0] {
        ERR_NONE, ERR_NO_UNIT, ERR_BAD_BLOCK, ERR_BAD_SYMBOL, ERR_TRUNC,
        ERR_EMPTY_HUNK
    } t_err;

    typedef enum logic [1:0] {
        KIND_NONE, KIND_CODE, KIND_DATA, KIND_BSS
    } t_kind;

    typedef struct packed {
        t_phase                 phase;
        logic [31:0]            skip_left;
        logic [COUNT_WIDTH-1:0] hunk_index;
        t_kind                  kind;
        logic [33:0]            bytes;
        logic [COUNT_WIDTH-1:0] def_count;
        logic                   far_mark;
        logic [7:0]             sym_type;
        logic                   name_first;
        t_err                   err;
    } t_state;

    typedef struct packed {
        t_role       word_role;
        logic [15:0] hunk_number;
        logic        hunk_done;
        logic [1:0]  hunk_kind;
        logic [33:0] hunk_bytes;
        logic [15:0] defined_symbols;
        logic        far_section;
        logic        module_done;
        logic [15:0] module_hunks;
        logic [2:0]  error;
    } t_result;

    function automatic t_state state_reset();
        t_state s;
        s.phase      = PH_UNIT;
        s.skip_left  = '0;
        s.hunk_index = '0;
        s.kind       = KIND_NONE;
        s.bytes      = '0;
        s.def_count  = '0;
        s.far_mark   = 1'b0;
        s.sym_type   = '0;
        s.name_first = 1'b0;
        s.err        = ERR_NONE;
        return s;
    endfunction

endpackage

// ===== sv/hunk_object_stream_parser.sv =====
// Hunk object stream parser: one result beat per file word.
// Each word passes the input register, then the result register; one word per cycle
// unless the result side stalls; the only loop is the parse state update in hosp_step.
// Reset: i_rst_n synchronous, active low; clears both stages and returns the parser
// to waiting for a unit header. The state also returns there after each last word.
`timescale 1ns / 1ps

module hunk_object_stream_parser (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // slave side: one file word per beat
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [hosp_pkg::WORD_W-1:0]  s_axis_tdata,   // [31:0] word
    input  logic                         s_axis_tlast,   // last_word
    // master side: one result per beat
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // [15:0] hunk_number, [16] hunk_done, [18:17] hunk_kind, [52:19] hunk_bytes,
    // [68:53] defined_symbols, [69] far_section, [85:70] module_hunks,
    // [88:86] error, [95:89] zero
    output logic [hosp_pkg::TDATA_W-1:0] m_axis_tdata,
    output logic [hosp_pkg::ROLE_W-1:0]  m_axis_tuser,   // word_role
    output logic                         m_axis_tlast    // module_done
);
    import hosp_pkg::*;

    // Input register
    logic        r_in_valid;
    logic [31:0] r_in_word;
    logic        r_in_last;

    // Parse state and result register
    t_state  r_state;
    t_state  n_state;
    t_result r_out;
    t_result n_out;
    logic    r_out_valid;

    logic advance;

    // Move a word into the result stage whenever that stage is empty or draining
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    hosp_step u_step (
        .i_state  (r_state),
        .i_word   (r_in_word),
        .i_last   (r_in_last),
        .o_state  (n_state),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= state_reset();
        end else begin
            // input stage: take a beat when it is free or is handing over
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            // result stage: load on advance, drop after the consumer takes it
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: no reset needed
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_word <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.word_role;
    assign m_axis_tlast  = r_out.module_done;
    assign m_axis_tdata  = {7'b0, r_out.error, r_out.module_hunks, r_out.far_section,
                            r_out.defined_symbols, r_out.hunk_bytes, r_out.hunk_kind,
                            r_out.hunk_done, r_out.hunk_number};

    // A hunk end result always carries the hunk end role
    a_hunk_done_role: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.hunk_done |-> r_out.word_role == ROLE_HUNK_END)
        else $error("hunk_done without hunk end role");

    // A latched error holds until the last word of the file
    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && !r_in_last && r_state.err != ERR_NONE
        |=> r_state.err == $past(r_state.err))
        else $error("latched error changed before last word");

    // The last word closes the module and returns the parser to the unit header
    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_last
        |=> r_out_valid && r_out.module_done && r_state.phase == PH_UNIT)
        else $error("last word did not close the module");

    // A held input word stays put while the result stage is blocked
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in_word))
        else $error("input word lost while stalled");

endmodule

// ===== sv/hosp_step.sv =====
// Next-state and result logic for one file word of the parser.
// Purely combinational; depends on hosp_pkg.
`timescale 1ns / 1ps

module hosp_step (
    input  hosp_pkg::t_state  i_state,
    input  logic [31:0]       i_word,
    input  logic              i_last,
    output hosp_pkg::t_state  o_state,
    output hosp_pkg::t_result o_result
);
    import hosp_pkg::*;

    function automatic logic known_symbol(input logic [7:0] t);
        return (t <= 8'd3) || (t == 8'd129) || (t == 8'd130) || (t == 8'd131) ||
               (t == 8'd132) || (t == 8'd134) || (t == 8'd135);
    endfunction

    t_state      n;
    t_result     r;
    logic        blk;
    logic [15:0] code;
    logic [7:0]  stype;
    logic        is_far;

    assign code   = i_word[15:0];
    assign stype  = i_word[31:24];
    assign is_far = ((i_word[31:24] | 8'h20) == 8'h66) &&
                    ((i_word[23:16] | 8'h20) == 8'h61) &&
                    ((i_word[15:8]  | 8'h20) == 8'h72);

    always_comb begin
        n   = i_state;
        r   = '0;
        blk = 1'b0;
        r.hunk_number = 16'(i_state.hunk_index);

        unique case (i_state.phase) inside
            PH_UNIT: begin
                r.word_role = ROLE_UNIT_ID;
                if (code == BLK_UNIT) begin
                    n.phase = PH_UNIT_LEN;
                end else begin
                    n.err   = ERR_NO_UNIT;
                    n.phase = PH_ERROR;
                end
            end
            PH_UNIT_LEN: begin
                r.word_role = ROLE_LENGTH;
                n.skip_left = i_word;
                n.phase     = (i_word != '0) ? PH_UNIT_NAME : PH_HUNK_START;
            end
            PH_UNIT_NAME: begin
                r.word_role = ROLE_NAME;
                n.skip_left = i_state.skip_left - 32'd1;
                if (n.skip_left == '0) n.phase = PH_HUNK_START;
            end
            PH_HUNK_START: begin
                if (code == BLK_UNIT) begin
                    // new unit closes the module
                    r.word_role    = ROLE_UNIT_ID;
                    r.module_done  = 1'b1;
                    r.module_hunks = 16'(i_state.hunk_index);
                    r.hunk_number  = '0;
                    n.hunk_index   = '0;
                    n.kind         = KIND_NONE;
                    n.bytes        = '0;
                    n.def_count    = '0;
                    n.far_mark     = 1'b0;
                    n.phase        = PH_UNIT_LEN;
                end else if (code == BLK_NAME) begin
                    r.word_role = ROLE_NAME_ID;
                    n.phase     = PH_HNAME_LEN;
                end else begin
                    blk = 1'b1;
                end
            end
            PH_HNAME_LEN: begin
                r.word_role  = ROLE_LENGTH;
                n.skip_left  = i_word;
                n.name_first = 1'b1;
                n.phase      = (i_word != '0) ? PH_HNAME : PH_BLOCK;
            end
            PH_HNAME: begin
                r.word_role = ROLE_NAME;
                if (i_state.name_first) begin
                    n.far_mark   = is_far;
                    n.name_first = 1'b0;
                end
                n.skip_left = i_state.skip_left - 32'd1;
                if (n.skip_left == '0) n.phase = PH_BLOCK;
            end
            PH_BLOCK: begin
                blk = 1'b1;
            end
            PH_CONT_LEN, PH_BSS_LEN, PH_DEBUG_LEN: begin
                r.word_role = ROLE_LENGTH;
                if (i_state.phase != PH_DEBUG_LEN) n.bytes = {i_word, 2'b00};
                n.skip_left = i_word;
                n.phase = (i_state.phase != PH_BSS_LEN && i_word != '0) ?
                          PH_CONTENT : PH_BLOCK;
            end
            PH_CONTENT: begin
                r.word_role = ROLE_CONTENT;
                n.skip_left = i_state.skip_left - 32'd1;
                if (n.skip_left == '0) n.phase = PH_BLOCK;
            end
            PH_RELOC_COUNT: begin
                r.word_role = ROLE_COUNT;
                n.skip_left = i_word;
                n.phase     = (i_word != '0) ? PH_RELOC_TARGET : PH_BLOCK;
            end
            PH_RELOC_TARGET: begin
                r.word_role = ROLE_RELOC_TARGET;
                n.phase     = PH_RELOC_OFFS;
            end
            PH_RELOC_OFFS: begin
                r.word_role = ROLE_RELOC_OFFS;
                n.skip_left = i_state.skip_left - 32'd1;
                if (n.skip_left == '0) n.phase = PH_RELOC_COUNT;
            end
            PH_SYM_HDR: begin
                r.word_role = ROLE_SYM_HDR;
                if (i_word == '0) begin
                    n.phase = PH_BLOCK;
                end else begin
                    n.sym_type = stype;
                    if (!known_symbol(stype)) begin
                        n.err   = ERR_BAD_SYMBOL;
                        n.phase = PH_ERROR;
                    end else begin
                        if ((stype == 8'd0 || stype == 8'd1 || stype == 8'd3) &&
                            i_state.def_count != COUNT_MAX) begin
                            n.def_count = i_state.def_count + COUNT_ONE;
                        end
                        n.skip_left = {8'h00, i_word[23:0] & SYM_LEN_MASK};
                        if (n.skip_left != '0) n.phase = PH_SYM_NAME;
                        else if (stype <= 8'd3 || stype == SYM_COMMON)
                            n.phase = PH_SYM_VALUE;
                        else n.phase = PH_REF_COUNT;
                    end
                end
            end
            PH_SYM_NAME: begin
                r.word_role = ROLE_NAME;
                n.skip_left = i_state.skip_left - 32'd1;
                if (n.skip_left == '0) begin
                    if (i_state.sym_type <= 8'd3 || i_state.sym_type == SYM_COMMON)
                        n.phase = PH_SYM_VALUE;
                    else n.phase = PH_REF_COUNT;
                end
            end
            PH_SYM_VALUE: begin
                r.word_role = ROLE_SYM_VALUE;
                n.phase     = PH_SYM_HDR;
            end
            PH_REF_COUNT: begin
                r.word_role = ROLE_COUNT;
                n.skip_left = i_word;
                n.phase     = (i_word != '0) ? PH_REF_OFFS : PH_SYM_HDR;
            end
            PH_REF_OFFS: begin
                r.word_role = ROLE_REFERENCE;
                n.skip_left = i_state.skip_left - 32'd1;
                if (n.skip_left == '0) n.phase = PH_SYM_HDR;
            end
            default: begin
                r.word_role = ROLE_IGNORED;
                n.phase     = PH_ERROR;
            end
        endcase

        // Block type decode, shared by hunk start and block phases
        if (blk) begin
            r.word_role = ROLE_BLOCK;
            if (i_word == WORD_END) begin
                r.word_role       = ROLE_HUNK_END;
                r.hunk_done       = 1'b1;
                r.hunk_kind       = i_state.kind;
                r.hunk_bytes      = i_state.bytes;
                r.defined_symbols = 16'(i_state.def_count);
                r.far_section     = i_state.far_mark;
                if (i_state.kind == KIND_NONE) begin
                    n.err   = ERR_EMPTY_HUNK;
                    n.phase = PH_ERROR;
                end else begin
                    if (i_state.hunk_index != COUNT_MAX)
                        n.hunk_index = i_state.hunk_index + COUNT_ONE;
                    n.kind      = KIND_NONE;
                    n.bytes     = '0;
                    n.def_count = '0;
                    n.far_mark  = 1'b0;
                    n.phase     = PH_HUNK_START;
                end
            end else begin
                unique case (code) inside
                    BLK_CODE: begin
                        n.kind = KIND_CODE; n.phase = PH_CONT_LEN;
                    end
                    BLK_DATA: begin
                        n.kind = KIND_DATA; n.phase = PH_CONT_LEN;
                    end
                    BLK_BSS: begin
                        n.kind = KIND_BSS; n.phase = PH_BSS_LEN;
                    end
                    BLK_RELOC32, BLK_RELOC16, BLK_RELOC8, BLK_DRELOC32:
                        n.phase = PH_RELOC_COUNT;
                    BLK_EXT, BLK_SYMBOL:
                        n.phase = PH_SYM_HDR;
                    BLK_DEBUG:
                        n.phase = PH_DEBUG_LEN;
                    default: begin
                        n.err   = ERR_BAD_BLOCK;
                        n.phase = PH_ERROR;
                    end
                endcase
            end
        end

        // Final word: flag truncation unless between hunks or already in error, close the module, return to reset
        if (i_last) begin
            if (n.err == ERR_NONE && n.phase != PH_HUNK_START) begin
                n.err   = ERR_TRUNC;
                n.phase = PH_ERROR;
            end
            if (!r.module_done) begin
                r.module_done  = 1'b1;
                r.module_hunks = 16'(n.hunk_index);
            end
        end
        r.error = n.err;
        if (i_last) n = state_reset();
    end

    assign o_state  = n;
    assign o_result = r;

endmodule

// ===== verif/tb_hunk_object_stream_parser.sv =====
// Self-checking testbench for hunk_object_stream_parser: drives hunk-format files as word beats
// and compares every result beat with a parse predictor held in a small scoreboard class.
// Depends on hosp_pkg (types, block codes) and the hunk_object_stream_parser RTL.
`timescale 1ns / 1ps

module tb_hunk_object_stream_parser;

    import hosp_pkg::*;

    localparam int RESET_CYCLES = 8;
    localparam int ITEM_TARGET  = 1000;
    localparam int HOLD_AT      = 300;  // result count at which the sink holds off
    localparam int HOLD_CYCLES  = 120;
    localparam int STALL_LIMIT  = 600;  // cycles with no beat on either side
    localparam int DRAIN_CYCLES = 10;

    // Symbol types of external/symbol blocks
    localparam logic [7:0] EXT_SYMB   = 8'd0;
    localparam logic [7:0] EXT_DEF    = 8'd1;
    localparam logic [7:0] EXT_ABS    = 8'd2;
    localparam logic [7:0] EXT_RES    = 8'd3;
    localparam logic [7:0] EXT_REF32  = 8'd129;
    localparam logic [7:0] EXT_COMMON = SYM_COMMON;
    localparam logic [7:0] EXT_REF16  = 8'd131;
    localparam logic [7:0] EXT_REF8   = 8'd132;
    localparam logic [7:0] EXT_DEXT32 = 8'd133;  // not handled by the parser
    localparam logic [7:0] EXT_DEXT16 = 8'd134;
    localparam logic [7:0] EXT_DEXT8  = 8'd135;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [WORD_W-1:0]   s_axis_tdata = '0;   // [31:0] word
    logic                s_axis_tlast = 1'b0; // last_word
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // [15:0] hunk_number, [16] hunk_done, [18:17] hunk_kind, [52:19] hunk_bytes,
    // [68:53] defined_symbols, [69] far_section, [85:70] module_hunks, [88:86] error
    logic [TDATA_W-1:0]  m_axis_tdata;
    logic [ROLE_W-1:0]   m_axis_tuser;        // word_role
    logic                m_axis_tlast;        // module_done

    hunk_object_stream_parser dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // ------------------------------------------------------------------
    // Parse predictor and store of due results
    // ------------------------------------------------------------------
    class parse_result_board;
        t_phase                 phase;
        logic [31:0]            skip;
        logic [COUNT_WIDTH-1:0] hunks;
        t_kind                  kind;
        logic [33:0]            bytes;
        logic [COUNT_WIDTH-1:0] defs;
        logic                   far;
        logic [7:0]             sym_type;
        logic                   name_first;
        t_err                   err;

        t_result due_results[$];
        int      fails;
        int      live_words;
        int      results_seen;

        function new();
            clear_all();
            fails = 0;
            live_words = 0;
            results_seen = 0;
        endfunction

        function void clear_hunk();
            kind  = KIND_NONE;
            bytes = '0;
            defs  = '0;
            far   = 1'b0;
        endfunction

        function void clear_all();
            clear_hunk();
            phase      = PH_UNIT;
            skip       = '0;
            hunks      = '0;
            sym_type   = '0;
            name_first = 1'b0;
            err        = ERR_NONE;
        endfunction

        function void latch_error(t_err code);
            err   = code;
            phase = PH_ERROR;
        endfunction

        // Common symbols and plain definitions carry one value word; the rest carry
        // a list of reference offsets.
        function void end_symbol_name();
            if (sym_type <= EXT_RES || sym_type == EXT_COMMON) begin
                phase = PH_SYM_VALUE;
            end else begin
                phase = PH_REF_COUNT;
            end
        endfunction

        function void decode_block(logic [31:0] w, inout t_result r);
            r.word_role = ROLE_BLOCK;
            // Hunk end must match in all 32 bits
            if (w == WORD_END) begin
                r.word_role       = ROLE_HUNK_END;
                r.hunk_done       = 1'b1;
                r.hunk_kind       = kind;
                r.hunk_bytes      = bytes;
                r.defined_symbols = 16'(defs);
                r.far_section     = far;
                if (kind == KIND_NONE) begin
                    latch_error(ERR_EMPTY_HUNK);
                end else begin
                    if (hunks != COUNT_MAX) hunks = hunks + COUNT_ONE;
                    clear_hunk();
                    phase = PH_HUNK_START;
                end
                return;
            end
            case (w[15:0]) inside
                BLK_CODE: begin
                    kind = KIND_CODE;
                    phase = PH_CONT_LEN;
                end
                BLK_DATA: begin
                    kind = KIND_DATA;
                    phase = PH_CONT_LEN;
                end
                BLK_BSS: begin
                    kind = KIND_BSS;
                    phase = PH_BSS_LEN;
                end
                BLK_RELOC32, BLK_RELOC16, BLK_RELOC8, BLK_DRELOC32: phase = PH_RELOC_COUNT;
                BLK_EXT, BLK_SYMBOL: phase = PH_SYM_HDR;
                BLK_DEBUG: phase = PH_DEBUG_LEN;
                default: latch_error(ERR_BAD_BLOCK);
            endcase
        endfunction

        function t_result decode_word(logic [31:0] w, logic last);
            t_result r;
            r = '0;
            r.hunk_number = 16'(hunks);
            case (phase) inside
                PH_UNIT: begin
                    r.word_role = ROLE_UNIT_ID;
                    if (w[15:0] == BLK_UNIT) phase = PH_UNIT_LEN;
                    else latch_error(ERR_NO_UNIT);
                end
                PH_UNIT_LEN: begin
                    r.word_role = ROLE_LENGTH;
                    skip = w;
                    phase = (w != 0) ? PH_UNIT_NAME : PH_HUNK_START;
                end
                PH_UNIT_NAME: begin
                    r.word_role = ROLE_NAME;
                    skip = skip - 1;
                    if (skip == 0) phase = PH_HUNK_START;
                end
                PH_HUNK_START: begin
                    if (w[15:0] == BLK_UNIT) begin
                        // a new unit closes the module
                        r.word_role    = ROLE_UNIT_ID;
                        r.module_done  = 1'b1;
                        r.module_hunks = 16'(hunks);
                        r.hunk_number  = '0;
                        hunks = '0;
                        clear_hunk();
                        phase = PH_UNIT_LEN;
                    end else if (w[15:0] == BLK_NAME) begin
                        r.word_role = ROLE_NAME_ID;
                        phase = PH_HNAME_LEN;
                    end else begin
                        decode_block(w, r);
                    end
                end
                PH_HNAME_LEN: begin
                    r.word_role = ROLE_LENGTH;
                    skip = w;
                    name_first = 1'b1;
                    phase = (w != 0) ? PH_HNAME : PH_BLOCK;
                end
                PH_HNAME: begin
                    r.word_role = ROLE_NAME;
                    if (name_first) begin
                        far = ((w[31:24] | 8'h20) == "f") && ((w[23:16] | 8'h20) == "a") &&
                              ((w[15:8] | 8'h20) == "r");
                        name_first = 1'b0;
                    end
                    skip = skip - 1;
                    if (skip == 0) phase = PH_BLOCK;
                end
                PH_BLOCK: decode_block(w, r);
                PH_CONT_LEN, PH_BSS_LEN, PH_DEBUG_LEN: begin
                    r.word_role = ROLE_LENGTH;
                    if (phase != PH_DEBUG_LEN) bytes = {w, 2'b00};
                    skip = w;
                    phase = (phase != PH_BSS_LEN && w != 0) ? PH_CONTENT : PH_BLOCK;
                end
                PH_CONTENT: begin
                    r.word_role = ROLE_CONTENT;
                    skip = skip - 1;
                    if (skip == 0) phase = PH_BLOCK;
                end
                PH_RELOC_COUNT: begin
                    r.word_role = ROLE_COUNT;
                    skip = w;
                    phase = (w != 0) ? PH_RELOC_TARGET : PH_BLOCK;
                end
                PH_RELOC_TARGET: begin
                    r.word_role = ROLE_RELOC_TARGET;
                    phase = PH_RELOC_OFFS;
                end
                PH_RELOC_OFFS: begin
                    r.word_role = ROLE_RELOC_OFFS;
                    skip = skip - 1;
                    if (skip == 0) phase = PH_RELOC_COUNT;
                end
                PH_SYM_HDR: begin
                    r.word_role = ROLE_SYM_HDR;
                    if (w == 0) begin
                        phase = PH_BLOCK;
                    end else begin
                        sym_type = w[31:24];
                        if (!(sym_type <= EXT_RES || sym_type == EXT_REF32 ||
                              sym_type == EXT_COMMON || sym_type == EXT_REF16 ||
                              sym_type == EXT_REF8 || sym_type == EXT_DEXT16 ||
                              sym_type == EXT_DEXT8)) begin
                            latch_error(ERR_BAD_SYMBOL);
                        end else begin
                            if ((sym_type == EXT_SYMB || sym_type == EXT_DEF ||
                                 sym_type == EXT_RES) && defs != COUNT_MAX) begin
                                defs = defs + COUNT_ONE;
                            end
                            skip = {8'h00, w[23:0] & SYM_LEN_MASK};
                            if (skip != 0) phase = PH_SYM_NAME;
                            else end_symbol_name();
                        end
                    end
                end
                PH_SYM_NAME: begin
                    r.word_role = ROLE_NAME;
                    skip = skip - 1;
                    if (skip == 0) end_symbol_name();
                end
                PH_SYM_VALUE: begin
                    r.word_role = ROLE_SYM_VALUE;
                    phase = PH_SYM_HDR;
                end
                PH_REF_COUNT: begin
                    r.word_role = ROLE_COUNT;
                    skip = w;
                    phase = (w != 0) ? PH_REF_OFFS : PH_SYM_HDR;
                end
                PH_REF_OFFS: begin
                    r.word_role = ROLE_REFERENCE;
                    skip = skip - 1;
                    if (skip == 0) phase = PH_SYM_HDR;
                end
                default: begin
                    r.word_role = ROLE_IGNORED;
                    phase = PH_ERROR;
                end
            endcase

            // Last word: flag truncation unless between hunks or already in error, then close the module
            if (last) begin
                if (err == ERR_NONE && phase != PH_HUNK_START) latch_error(ERR_TRUNC);
                if (!r.module_done) begin
                    r.module_done  = 1'b1;
                    r.module_hunks = 16'(hunks);
                end
            end
            r.error = err;
            if (last) clear_all();
            return r;
        endfunction

        function void note_word(logic [31:0] w, logic last);
            t_result r;
            r = decode_word(w, last);
            if (r.word_role != ROLE_IGNORED) live_words++;
            due_results.push_back(r);
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        task report(string msg);
            fails++;
            $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task field_check(string name, logic [33:0] got, logic [33:0] want);
            if (got !== want) begin
                report($sformatf("result %0d %s got %0h want %0h", results_seen, name, got,
                                 want));
            end
        endtask

        task check_result(logic [TDATA_W-1:0] d, logic [ROLE_W-1:0] role, logic closed);
            t_result want;
            if (due_results.size() == 0) begin
                report($sformatf("result %0d arrived with nothing outstanding", results_seen));
                results_seen++;
                return;
            end
            want = due_results.pop_front();
            field_check("word_role", 34'(role), 34'(want.word_role));
            field_check("hunk_number", 34'(d[15:0]), 34'(want.hunk_number));
            field_check("hunk_done", 34'(d[16]), 34'(want.hunk_done));
            field_check("hunk_kind", 34'(d[18:17]), 34'(want.hunk_kind));
            field_check("hunk_bytes", d[52:19], want.hunk_bytes);
            field_check("defined_symbols", 34'(d[68:53]), 34'(want.defined_symbols));
            field_check("far_section", 34'(d[69]), 34'(want.far_section));
            field_check("module_hunks", 34'(d[85:70]), 34'(want.module_hunks));
            field_check("error", 34'(d[88:86]), 34'(want.error));
            field_check("module_done", 34'(closed), 34'(want.module_done));
            results_seen++;
        endtask
    endclass

    parse_result_board board;
    logic [31:0]       file_q[$];
    bit                send_calm = 1'b0;
    int                idle_cycles = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Sender: one file word per beat, with a random gap before each
    // ------------------------------------------------------------------
    task automatic push_word(input logic [31:0] w, input logic last);
        int gap;
        gap = send_calm ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic send_file();
        foreach (file_q[i]) push_word(file_q[i], i == file_q.size() - 1);
    endtask

    // Block code, now and then with junk in the upper half (matched on the low half)
    task automatic add_code(input logic [15:0] code);
        logic [15:0] upper;
        upper = ($urandom_range(0, 7) == 0) ? 16'($urandom()) : 16'h0000;
        file_q.push_back({upper, code});
    endtask

    task automatic add_words(input int n);
        repeat (n) file_q.push_back($urandom());
    endtask

    // One hunk with random content, mostly well-formed
    task automatic add_hunk();
        int         n;
        int         refs;
        bit         filled;
        logic [7:0] sym;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        filled = 1'b0;
        if ($urandom_range(0, 1) == 1) begin
            add_code(BLK_NAME);
            n = $urandom_range(0, 2);
            file_q.push_back(32'(n));
            if (n > 0) begin
                // "far" in mixed case, sometimes spoilt by one flipped bit
                b0 = ($urandom_range(0, 1) == 1) ? "f" : "F";
                b1 = ($urandom_range(0, 1) == 1) ? "a" : "A";
                b2 = ($urandom_range(0, 1) == 1) ? "r" : "R";
                if ($urandom_range(0, 2) == 0) begin
                    file_q.push_back({b0, b1, b2, 8'($urandom())} ^
                                     (32'h100 << $urandom_range(0, 23)));
                end else begin
                    file_q.push_back({b0, b1, b2, 8'($urandom())});
                end
                add_words(n - 1);
            end
        end
        repeat ($urandom_range(1, 4)) begin
            case ($urandom_range(0, 6))
                0, 1: begin
                    if ($urandom_range(0, 1) == 1) add_code(BLK_CODE);
                    else add_code(BLK_DATA);
                    n = $urandom_range(0, 3);
                    file_q.push_back(32'(n));
                    add_words(n);
                    filled = 1'b1;
                end
                2: begin
                    add_code(BLK_BSS);
                    file_q.push_back(($urandom_range(0, 7) == 0) ? $urandom() :
                                     32'($urandom_range(0, 64)));
                    filled = 1'b1;
                end
                3: begin
                    case ($urandom_range(0, 3))
                        0: add_code(BLK_RELOC32);
                        1: add_code(BLK_RELOC16);
                        2: add_code(BLK_RELOC8);
                        default: add_code(BLK_DRELOC32);
                    endcase
                    repeat ($urandom_range(0, 2)) begin
                        n = $urandom_range(1, 3);
                        file_q.push_back(32'(n));
                        add_words(n + 1);  // target then offsets
                    end
                    file_q.push_back(32'h0);
                end
                4, 5: begin
                    if ($urandom_range(0, 1) == 1) add_code(BLK_EXT);
                    else add_code(BLK_SYMBOL);
                    repeat ($urandom_range(0, 3)) begin
                        case ($urandom_range(0, 9))
                            0: sym = EXT_SYMB;
                            1: sym = EXT_DEF;
                            2: sym = EXT_ABS;
                            3: sym = EXT_RES;
                            4: sym = EXT_REF32;
                            5: sym = EXT_COMMON;
                            6: sym = EXT_REF16;
                            7: sym = EXT_REF8;
                            8: sym = EXT_DEXT16;
                            default: sym = EXT_DEXT8;
                        endcase
                        if ($urandom_range(0, 29) == 0) sym = 8'($urandom());
                        n = $urandom_range(0, 2);
                        // a zero header word would end the list
                        if (sym == EXT_SYMB && n == 0) n = 1;
                        file_q.push_back({sym, 24'(n)});
                        add_words(n);
                        if (sym <= EXT_RES || sym == EXT_COMMON) begin
                            add_words(1);
                        end else begin
                            refs = $urandom_range(0, 2);
                            file_q.push_back(32'(refs));
                            add_words(refs);
                        end
                    end
                    file_q.push_back(32'h0);
                end
                default: begin
                    add_code(BLK_DEBUG);
                    n = $urandom_range(0, 3);
                    file_q.push_back(32'(n));
                    add_words(n);
                end
            endcase
        end
        // Leave a hunk empty only now and then
        if (!filled && $urandom_range(0, 7) != 0) begin
            add_code(BLK_CODE);
            file_q.push_back(32'd1);
            add_words(1);
        end
        file_q.push_back(WORD_END);
    endtask

    // Mostly well-formed files; a third are cut short, corrupted or pure noise
    task automatic send_random_file();
        int n;
        int at;
        file_q.delete();
        repeat ($urandom_range(1, 2)) begin
            add_code(BLK_UNIT);
            n = $urandom_range(0, 2);
            file_q.push_back(32'(n));
            add_words(n);
            repeat ($urandom_range(0, 3)) add_hunk();
        end
        at = $urandom_range(0, file_q.size() - 1);
        case ($urandom_range(0, 11))
            0: file_q = file_q[0:at];
            1: file_q[at] = $urandom();
            2: begin
                case ($urandom_range(0, 4))
                    0: file_q[at] = {16'h0000, BLK_UNIT};
                    1: file_q[at] = {16'h0000, BLK_NAME};
                    2: file_q[at] = WORD_END;
                    3: file_q[at] = {16'h8000, WORD_END[15:0]};
                    default: file_q[at] = {EXT_DEXT32, 24'd0};
                endcase
            end
            3: begin
                file_q.delete();
                add_words($urandom_range(1, 4));
            end
            default: ;
        endcase
        send_calm = ($urandom_range(0, 3) == 0);
        send_file();
    endtask

    // ------------------------------------------------------------------
    // Monitor: note each word beat, check each result beat
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) board.note_word(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready) begin
                board.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
            end
        end
    end

    // Watchdog: give up once no beat has moved on either side for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Result sink: random stalls, calm stretches and one long hold-off
    // ------------------------------------------------------------------
    initial begin : result_sink
        int stall;
        int taken;
        bit calm;
        taken = 0;
        calm  = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (taken % 64 == 0) calm = ($urandom_range(0, 3) == 0);
            // Hold off long enough for the parser to fill and stall its input
            if (taken == HOLD_AT) stall = HOLD_CYCLES;
            else if (calm) stall = 0;
            else stall = $urandom_range(0, 4);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            taken++;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        board = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: full module with a far-named code hunk (content extremes, a
        // defined symbol, a reference), a second module with a maximal bss hunk
        // ending on the last word, then no unit header, a hunk end with upper bits
        // set and an empty hunk.
        file_q = '{{16'hFFFF, BLK_UNIT}, 32'd0, {16'h0000, BLK_NAME}, 32'd1,
                   32'h6641_5258, {16'h0001, BLK_CODE}, 32'd2, 32'hFFFF_FFFF, 32'h0,
                   {16'h0000, BLK_EXT}, {EXT_RES, 24'd1}, 32'h1234_5678, 32'h10,
                   {EXT_REF32, 24'd0}, 32'd1, 32'h4, 32'h0, WORD_END,
                   {16'h0000, BLK_UNIT}, 32'd0, {16'h0000, BLK_BSS}, 32'hFFFF_FFFF,
                   WORD_END};
        send_file();
        file_q = '{32'h0000_0123};
        send_file();
        file_q = '{{16'h0000, BLK_UNIT}, 32'd0, {16'h0001, WORD_END[15:0]}};
        send_file();
        file_q = '{{16'h0000, BLK_UNIT}, 32'd0, WORD_END};
        send_file();

        while (board.live_words < ITEM_TARGET) send_random_file();
        s_axis_tvalid <= 1'b0;

        // Drain: wait for every due result, then wait out DRAIN_CYCLES for strays
        while (board.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.fails == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/hosp_pkg.sv
sv/hosp_step.sv
sv/hunk_object_stream_parser.sv
verif/tb_hunk_object_stream_parser.sv
